>>> rtl/core/blh_pkg.sv
package blh_pkg;

	localparam int MOL_TYPES     = 4;
	localparam int BEAD_TYPES    = 8;
	localparam int SLOTS_PER_MOL = 16;
	localparam int BINS          = 64;

	localparam int PAIR_KEYS = MOL_TYPES * BEAD_TYPES * BEAD_TYPES;
	localparam int BOND_KEYS = MOL_TYPES * SLOTS_PER_MOL;
	localparam int PAIR_KW   = $clog2(PAIR_KEYS);
	localparam int BOND_KW   = $clog2(BOND_KEYS);
	localparam int PH_DEPTH  = PAIR_KEYS * BINS;
	localparam int BH_DEPTH  = BOND_KEYS * BINS;
	localparam int PH_AW     = $clog2(PH_DEPTH);
	localparam int BH_AW     = $clog2(BH_DEPTH);

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int LEN_W    = 32;
	localparam int RAD_W    = 2 * LEN_W;
	localparam int REM_W    = LEN_W + 4;
	localparam int CNT_W    = $clog2(DIFF_W + 1);

	localparam logic [1:0] REG_BIN_WIDTH   = 2'd0;
	localparam logic [1:0] REG_BIN_COUNT   = 2'd1;
	localparam logic [1:0] REG_WARN_ENABLE = 2'd2;
	localparam logic [1:0] REG_WARN_LIMIT  = 2'd3;

	typedef enum logic [1:0] {
		REQ_ADD      = 2'd0,
		REQ_PAIR_BIN = 2'd1,
		REQ_BOND_BIN = 2'd2,
		REQ_STATS    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		L_IDLE,
		L_SQUARE,
		L_ROOT,
		L_DIVIDE
	} len_state_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LEN,
		S_READ,
		S_UPDATE
	} ctl_state_t;

	typedef struct packed {
		logic             done;
		logic [LEN_W-1:0] length;
		logic [LEN_W-1:0] bin;
	} len_res_t;

endpackage

>>> rtl/core/bond_length_histogram.sv
// Bond length histogram. Each input transaction is one request: add a bond
// (two 3D bead positions, signed Q16.16) or read a pair bin, a per-bond bin or
// the min/max/sum statistics of a bead-type pair. An add computes the
// Euclidean length (floor of the exact root, saturated at 0xFFFFFFFF) and the
// bin floor(length / bin_width), and counts it in both histograms when the bin
// is below bin_count and below 64. Every request returns exactly one output
// transaction; unused fields are zero. An add passes through the bit-serial
// length unit (shift-add squaring, square root, division, then a completion
// flag), then a memory read and a write-back, and the block returns to idle
// to take the next request. A read does one registered memory read and a
// write-back. A stalled output holds the block in write-back while the output
// register is still full. After reset the block sweeps every store to its
// reset value, one pair-histogram entry per cycle, and stalls input until the
// sweep ends; register writes are taken during the sweep. The next request is
// accepted while a finished result still waits at the output. Configuration
// is at byte addresses 0x0 bin_width, 0x4 bin_count, 0x8 warn_enable, 0xC
// warn_limit; write only while idle.
module bond_length_histogram import blh_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB-style register port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// request channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [1:0]                mol_type,
	input  logic [2:0]                type_first,
	input  logic [2:0]                type_second,
	input  logic [3:0]                bond_slot,
	input  logic signed [COORD_W-1:0] first_x,
	input  logic signed [COORD_W-1:0] first_y,
	input  logic signed [COORD_W-1:0] first_z,
	input  logic signed [COORD_W-1:0] second_x,
	input  logic signed [COORD_W-1:0] second_y,
	input  logic signed [COORD_W-1:0] second_z,
	input  logic [5:0]                read_bin,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [31:0]               bond_length,
	output logic [5:0]                bin_number,
	output logic                      in_range,
	output logic                      too_long,
	output logic [31:0]               bin_value,
	output logic [31:0]               min_length,
	output logic [31:0]               max_length,
	output logic [63:0]               length_sum
);

	// configuration
	logic [31:0] bin_width_q;
	logic [6:0]  bin_count_q;
	logic        warn_enable_q;
	logic [31:0] warn_limit_q;

	ctl_state_t state_q, state_d;
	logic [PH_AW-1:0] clr_q;

	// request held for the whole transaction
	req_t       req_q;
	logic [1:0] mol_q;
	logic [2:0] lo_q, hi_q;
	logic [3:0] slot_q;
	logic [5:0] rbin_q;

	len_res_t lres;

	// stores (no reset; cleared by the sweep)
	logic [31:0] ph_mem [PH_DEPTH];
	logic [31:0] bh_mem [BH_DEPTH];
	logic [31:0] mn_mem [PAIR_KEYS];
	logic [31:0] mx_mem [PAIR_KEYS];
	logic [63:0] tot_mem [PAIR_KEYS];
	logic [31:0] ph_rd_q, bh_rd_q, mn_rd_q, mx_rd_q;
	logic [63:0] tot_rd_q;

	logic accept, cfg_wr, out_free, clearing, rd_en;
	logic key_ok, slot_ok, rbin_ok, counted;
	logic [PAIR_KW-1:0] pk;
	logic [BOND_KW-1:0] bk;
	logic [$clog2(BINS)-1:0] bin_sel;
	logic [PH_AW-1:0] ph_addr, ph_wa;
	logic [BH_AW-1:0] bh_addr, bh_wa;
	logic [PAIR_KW-1:0] st_wa;
	logic ph_we, bh_we, st_we;
	logic [31:0] ph_wd, bh_wd, mn_wd, mx_wd;
	logic [63:0] tot_wd, tot_sum;
	logic [6:0] limit;

	// next output fields
	logic [31:0] nx_length, nx_value, nx_min, nx_max;
	logic [5:0]  nx_bin;
	logic        nx_range, nx_long;
	logic [63:0] nx_sum;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid || !out_stall;
	assign clearing = state_q == S_CLEAR;
	assign rd_en    = state_q == S_READ;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q   <= 32'd65536;
			bin_count_q   <= 7'd64;
			warn_enable_q <= 1'b0;
			warn_limit_q  <= '1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BIN_WIDTH:   bin_width_q   <= pwdata;
				REG_BIN_COUNT:   bin_count_q   <= pwdata[6:0];
				REG_WARN_ENABLE: warn_enable_q <= pwdata[0];
				REG_WARN_LIMIT:  warn_limit_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BIN_WIDTH:   prdata = bin_width_q;
			REG_BIN_COUNT:   prdata = {25'd0, bin_count_q};
			REG_WARN_ENABLE: prdata = {31'd0, warn_enable_q};
			REG_WARN_LIMIT:  prdata = warn_limit_q;
			default:         prdata = '0;
		endcase
	end

	// capture the request; bead types sorted into the pair key
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req_t'(req_type);
			mol_q  <= mol_type;
			lo_q   <= (type_first < type_second) ? type_first : type_second;
			hi_q   <= (type_first < type_second) ? type_second : type_first;
			slot_q <= bond_slot;
			rbin_q <= read_bin;
		end
	end

	blh_length u_length (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && req_t'(req_type) == REQ_ADD),
		.first_x   (first_x),
		.first_y   (first_y),
		.first_z   (first_z),
		.second_x  (second_x),
		.second_y  (second_y),
		.second_z  (second_z),
		.bin_width (bin_width_q),
		.res       (lres)
	);

	// keys and addresses
	assign key_ok  = (int'(mol_q) < MOL_TYPES) && (int'(hi_q) < BEAD_TYPES);
	assign slot_ok = int'(slot_q) < SLOTS_PER_MOL;
	assign rbin_ok = int'(rbin_q) < BINS;
	assign pk = PAIR_KW'((int'(mol_q) * BEAD_TYPES + int'(lo_q)) * BEAD_TYPES + int'(hi_q));
	assign bk = BOND_KW'(int'(mol_q) * SLOTS_PER_MOL + int'(slot_q));
	assign limit = (int'(bin_count_q) < BINS) ? bin_count_q : 7'(BINS);
	assign counted = key_ok && (lres.bin < {25'd0, limit});
	assign bin_sel = (req_q == REQ_ADD) ? lres.bin[$clog2(BINS)-1:0]
		: rbin_q[$clog2(BINS)-1:0];
	assign ph_addr = PH_AW'(int'(pk) * BINS + int'(bin_sel));
	assign bh_addr = BH_AW'(int'(bk) * BINS + int'(bin_sel));

	// write-back values; saturating updates
	assign tot_sum = tot_rd_q + {32'd0, lres.length};
	always_comb begin
		ph_we  = clearing;
		bh_we  = clearing;
		st_we  = clearing;
		ph_wa  = clearing ? clr_q : ph_addr;
		bh_wa  = clearing ? clr_q[BH_AW-1:0] : bh_addr;
		st_wa  = clearing ? clr_q[PAIR_KW-1:0] : pk;
		ph_wd  = '0;
		bh_wd  = '0;
		mn_wd  = '1;
		mx_wd  = '0;
		tot_wd = '0;
		if (state_q == S_UPDATE && req_q == REQ_ADD && key_ok) begin
			st_we  = 1'b1;
			mn_wd  = (lres.length < mn_rd_q) ? lres.length : mn_rd_q;
			mx_wd  = (lres.length > mx_rd_q) ? lres.length : mx_rd_q;
			tot_wd = (tot_sum < tot_rd_q) ? '1 : tot_sum;
			ph_we  = counted;
			bh_we  = counted && slot_ok;
			ph_wd  = (ph_rd_q == '1) ? ph_rd_q : ph_rd_q + 32'd1;
			bh_wd  = (bh_rd_q == '1) ? bh_rd_q : bh_rd_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ph_we)
			ph_mem[ph_wa] <= ph_wd;
		if (rd_en)
			ph_rd_q <= ph_mem[ph_addr];
	end

	always_ff @(posedge clk) begin
		if (bh_we)
			bh_mem[bh_wa] <= bh_wd;
		if (rd_en)
			bh_rd_q <= bh_mem[bh_addr];
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			mn_mem[st_wa]  <= mn_wd;
			mx_mem[st_wa]  <= mx_wd;
			tot_mem[st_wa] <= tot_wd;
		end
		if (rd_en) begin
			mn_rd_q  <= mn_mem[pk];
			mx_rd_q  <= mx_mem[pk];
			tot_rd_q <= tot_mem[pk];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing)
				clr_q <= clr_q + PH_AW'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_q == '1) state_d = S_IDLE;
			S_IDLE: begin
				if (accept)
					state_d = (req_t'(req_type) == REQ_ADD) ? S_LEN : S_READ;
			end
			S_LEN:    if (lres.done) state_d = S_READ;
			S_READ:   state_d = S_UPDATE;
			// hold here until the output register frees; rewrites are idempotent
			S_UPDATE: if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (state_q == S_UPDATE && out_free)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	// fields a request does not produce stay zero
	always_comb begin
		nx_length = '0;
		nx_bin    = '0;
		nx_range  = 1'b0;
		nx_long   = 1'b0;
		nx_value  = '0;
		nx_min    = '0;
		nx_max    = '0;
		nx_sum    = '0;
		case (req_q)
			REQ_ADD: begin
				nx_length = lres.length;
				nx_bin    = (lres.bin > 32'd63) ? 6'd63 : lres.bin[5:0];
				nx_range  = counted;
				nx_long   = warn_enable_q && (lres.length > warn_limit_q);
			end
			REQ_PAIR_BIN: begin
				if (key_ok && rbin_ok)
					nx_value = ph_rd_q;
			end
			REQ_BOND_BIN: begin
				if (key_ok && slot_ok && rbin_ok)
					nx_value = bh_rd_q;
			end
			default: begin
				if (key_ok) begin
					nx_min = mn_rd_q;
					nx_max = mx_rd_q;
					nx_sum = tot_rd_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE && out_free) begin
			bond_length <= nx_length;
			bin_number  <= nx_bin;
			in_range    <= nx_range;
			too_long    <= nx_long;
			bin_value   <= nx_value;
			min_length  <= nx_min;
			max_length  <= nx_max;
			length_sum  <= nx_sum;
		end
	end

	a_done_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		lres.done |-> state_q == S_LEN)
		else $error("length unit finished outside S_LEN");

	a_out_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_UPDATE))
		else $error("result appeared without an update cycle");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_LEN) |-> !(ph_we || bh_we || st_we))
		else $error("store written while no transaction updates");

endmodule

>>> rtl/core/blh_length.sv
module blh_length import blh_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [COORD_W-1:0] first_x,
	input  logic signed [COORD_W-1:0] first_y,
	input  logic signed [COORD_W-1:0] first_z,
	input  logic signed [COORD_W-1:0] second_x,
	input  logic signed [COORD_W-1:0] second_y,
	input  logic signed [COORD_W-1:0] second_z,
	input  logic [LEN_W-1:0]          bin_width,
	output len_res_t                  res
);

	function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic [DIFF_W-1:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
	endfunction

	len_state_t lst_q, lst_d;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [SQ_W-1:0]   mc_q [3];
	logic [DIFF_W-1:0] mp_q [3];
	logic [SQ_W-1:0]   acc_q;
	logic              ovf_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [LEN_W-1:0]  root_q;
	logic [LEN_W:0]    drem_q;
	logic [LEN_W-1:0]  dvd_q;
	logic [LEN_W-1:0]  len_q;

	logic [DIFF_W-1:0] mag [3];
	logic [SQ_W-1:0]   acc_next;
	logic [REM_W-1:0]  rem_in, trial;
	logic              root_ge;
	logic [LEN_W-1:0]  root_next;
	logic [LEN_W:0]    dtrial;
	logic              div_ge;
	logic              last_sq, last_step;

	assign mag[0] = abs_diff(first_x, second_x);
	assign mag[1] = abs_diff(first_y, second_y);
	assign mag[2] = abs_diff(first_z, second_z);

	assign acc_next = acc_q + (mp_q[0][0] ? mc_q[0] : '0) + (mp_q[1][0] ? mc_q[1] : '0)
		+ (mp_q[2][0] ? mc_q[2] : '0);

	// restoring square root, two radicand bits per step
	assign rem_in    = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign root_ge   = rem_in >= trial;
	assign root_next = {root_q[LEN_W-2:0], root_ge};

	// restoring divide, one quotient bit per step
	assign dtrial = {drem_q[LEN_W-1:0], dvd_q[LEN_W-1]};
	assign div_ge = dtrial >= {1'b0, bin_width};

	assign last_sq   = cnt_q == CNT_W'(DIFF_W);
	assign last_step = cnt_q == CNT_W'(LEN_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lst_q  <= L_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			lst_q  <= lst_d;
			done_q <= (lst_q == L_DIVIDE) && last_step;
			if (lst_q != lst_d || start)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		lst_d = lst_q;
		unique case (lst_q)
			L_IDLE:   if (start) lst_d = L_SQUARE;
			L_SQUARE: if (last_sq) lst_d = L_ROOT;
			L_ROOT:   if (last_step) lst_d = L_DIVIDE;
			L_DIVIDE: if (last_step) lst_d = L_IDLE;
			default:  lst_d = L_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (lst_q)
			L_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						mc_q[i] <= SQ_W'(mag[i]);
						mp_q[i] <= mag[i];
					end
					acc_q <= '0;
				end
			end
			L_SQUARE: begin
				if (last_sq) begin
					ovf_q  <= |acc_q[SQ_W-1:RAD_W];
					rad_q  <= acc_q[RAD_W-1:0];
					rem_q  <= '0;
					root_q <= '0;
				end else begin
					acc_q <= acc_next;
					for (int i = 0; i < 3; i++) begin
						mc_q[i] <= {mc_q[i][SQ_W-2:0], 1'b0};
						mp_q[i] <= {1'b0, mp_q[i][DIFF_W-1:1]};
					end
				end
			end
			L_ROOT: begin
				rem_q  <= root_ge ? rem_in - trial : rem_in;
				root_q <= root_next;
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				if (last_step) begin
					len_q  <= ovf_q ? '1 : root_next;
					dvd_q  <= ovf_q ? '1 : root_next;
					drem_q <= '0;
				end
			end
			L_DIVIDE: begin
				drem_q <= div_ge ? dtrial - {1'b0, bin_width} : dtrial;
				dvd_q  <= {dvd_q[LEN_W-2:0], div_ge};
			end
			default: ;
		endcase
	end

	assign res.done   = done_q;
	assign res.length = len_q;
	assign res.bin    = (bin_width == '0) ? '1 : dvd_q;

endmodule
